// ===== design/assert_macros.svh =====
// Assertion macros used by the converter top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define EUQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define EUQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/euq_pkg.sv =====
// Types and constants for the Euler-angle to quaternion converter.
package euq_pkg;

  localparam int NUM_ANG = 3;
  localparam int QDEPTH  = 16;
  localparam int QAW     = $clog2(QDEPTH);

  typedef struct packed {
    logic signed [31:0] pitch_deg;
    logic signed [31:0] yaw_deg;
    logic signed [31:0] roll_deg;
  } euq_in_t;

  typedef struct packed {
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
  } euq_out_t;

  // half angle as binary angle (2^32 per turn), folded into a quarter turn
  typedef struct packed {
    logic              flip;
    logic signed [31:0] ang;
  } euq_half_t;

  typedef euq_half_t [NUM_ANG-1:0] euq_qword_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } euq_qstat_t;

  // divide by 45 via reciprocal: floor(2^32 / 45)
  localparam logic [26:0] RECIP45      = 27'd95443717;
  localparam logic [5:0]  MOD_CONST    = 6'd45;
  // 2^31 = 45 * TWO31_DIV45 + TWO31_MOD45
  localparam logic [25:0] TWO31_DIV45  = 26'd47721858;
  localparam logic [5:0]  TWO31_MOD45  = 6'd38;
  // rounding bias of the degrees-to-turns division, after the power-of-two part
  localparam logic [31:0] HALF_DIV_BIAS = 32'd22;

  localparam logic signed [32:0] QUARTER_TURN = 33'sd1073741824;
  localparam logic signed [32:0] HALF_TURN    = 33'sd2147483648;

  localparam logic signed [33:0] INV_GAIN = 34'sh026DD3B6A;

  localparam logic signed [15:0] SAT_MAX = 16'sh7FFF;
  localparam logic signed [15:0] SAT_MIN = -16'sh8000;

  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

endpackage

// ===== design/euq_front.sv =====
// Front end: accepts angle words, reduces modulo 360 and forms folded half angles.
module euq_front #(
  parameter int ANGLE_FRAC_BITS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  euq_pkg::euq_in_t    in_word,
  input  logic                q_pop,
  output logic                q_push,
  output euq_pkg::euq_qword_t q_data
);
  import euq_pkg::*;

  localparam int SF  = ANGLE_FRAC_BITS + 3;
  localparam int HW  = 32 - SF;
  localparam int LSH = 28 - ANGLE_FRAC_BITS;
  localparam int NST = 7;
  localparam int OW  = QAW + 1;

  logic               in_acc;
  logic [OW-1:0]      occ_r, occ_nxt;
  logic [NST-1:0]     v_r;
  logic signed [31:0] deg_in [NUM_ANG];

  assign deg_in[0] = in_word.pitch_deg;
  assign deg_in[1] = in_word.yaw_deg;
  assign deg_in[2] = in_word.roll_deg;

  // occupancy counts words in flight here plus words held in the queue
  assign in_stall = (occ_r == OW'(QDEPTH));
  assign in_acc   = in_valid && !in_stall;
  assign occ_nxt  = occ_r + OW'(in_acc) - OW'(q_pop);
  assign q_push   = v_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
      v_r   <= '0;
    end else begin
      occ_r <= occ_nxt;
      v_r   <= {v_r[NST-2:0], in_acc};
    end
  end

  for (genvar g = 0; g < NUM_ANG; g++) begin : g_lane
    logic [31:0]        mag;
    logic [63:0]        prod_b, prod_e;
    logic [HW-1:0]      rem_full;
    logic [5:0]         rem_c;
    logic [31:0]        rem2;
    logic signed [32:0] sa, fl;
    logic               flip;

    logic               neg_a_r, neg_b_r, neg_c_r, neg_d_r, neg_e_r, neg_f_r;
    logic [HW-1:0]      h_a_r, h_b_r, q_b_r;
    logic [SF-1:0]      low_a_r, low_b_r, low_c_r;
    logic [5:0]         rem_c_r;
    logic [31:0]        w_d_r, qa_d_r, w_e_r, qa_e_r, q2_e_r, q_f_r;
    euq_half_t          out_g_r;

    always_comb begin
      mag      = deg_in[g][31] ? 32'(-deg_in[g]) : 32'(deg_in[g]);
      prod_b   = 64'(h_a_r) * 64'(RECIP45);
      rem_full = h_b_r - q_b_r * HW'(MOD_CONST);
      rem_c    = (rem_full >= HW'(MOD_CONST)) ? 6'(rem_full - HW'(MOD_CONST)) : 6'(rem_full);
      prod_e   = 64'(w_d_r) * 64'(RECIP45);
      rem2     = w_e_r - q2_e_r * 32'(MOD_CONST);
      sa       = neg_f_r ? -$signed({1'b0, q_f_r}) : $signed({1'b0, q_f_r});
      flip     = 1'b1;
      if (sa > QUARTER_TURN) begin
        fl = sa - HALF_TURN;
      end else if (sa < -QUARTER_TURN) begin
        fl = sa + HALF_TURN;
      end else begin
        fl   = sa;
        flip = 1'b0;
      end
    end

    always_ff @(posedge clk) begin
      neg_a_r <= deg_in[g][31];
      h_a_r   <= mag[31:SF];
      low_a_r <= mag[SF-1:0];

      neg_b_r <= neg_a_r;
      h_b_r   <= h_a_r;
      low_b_r <= low_a_r;
      q_b_r   <= prod_b[32 +: HW];

      neg_c_r <= neg_b_r;
      low_c_r <= low_b_r;
      rem_c_r <= rem_c;

      neg_d_r <= neg_c_r;
      w_d_r   <= 32'(rem_c_r) * 32'(TWO31_MOD45) + (32'(low_c_r) << LSH) + HALF_DIV_BIAS;
      qa_d_r  <= 32'(rem_c_r) * 32'(TWO31_DIV45);

      neg_e_r <= neg_d_r;
      w_e_r   <= w_d_r;
      qa_e_r  <= qa_d_r;
      q2_e_r  <= prod_e[63:32];

      neg_f_r <= neg_e_r;
      q_f_r   <= qa_e_r + q2_e_r + 32'(rem2 >= 32'(MOD_CONST));

      out_g_r.flip <= flip;
      out_g_r.ang  <= 32'(fl);
    end

    assign q_data[g] = out_g_r;
  end

endmodule

// ===== design/euq_fifo.sv =====
// Short queue between the front end and the back end.
module euq_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  euq_pkg::euq_qword_t wdata,
  input  logic                pop,
  output euq_pkg::euq_qword_t rdata,
  output euq_pkg::euq_qstat_t stat
);
  import euq_pkg::*;

  logic [QAW-1:0] wp_r, rp_r;
  logic [QAW:0]   cnt_r;
  euq_qword_t     mem_r [QDEPTH];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end

  assign rdata          = mem_r[rp_r];
  assign stat.not_empty = (cnt_r != '0);
  assign stat.full      = (cnt_r == (QAW+1)'(QDEPTH));

endmodule

// ===== design/euq_back.sv =====
// Back end: CORDIC sine/cosine pipeline, quaternion products and output register.
module euq_back #(
  parameter int CORDIC_STEPS  = 16,
  parameter int OUT_FRAC_BITS = 15
) (
  input  logic                clk,
  input  logic                rst_n,
  input  euq_pkg::euq_qstat_t q_stat,
  input  euq_pkg::euq_qword_t q_data,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output euq_pkg::euq_out_t   out_word
);
  import euq_pkg::*;

  localparam int NB  = CORDIC_STEPS + 6;
  localparam int OSH = 60 - OUT_FRAC_BITS;

  logic           en;
  logic [NB-1:0]  vb_r;
  logic           out_valid_r;
  euq_out_t       out_word_r;

  logic signed [33:0] cord_x_r [NUM_ANG][CORDIC_STEPS+1];
  logic signed [33:0] cord_y_r [NUM_ANG][CORDIC_STEPS+1];
  logic signed [33:0] cord_a_r [NUM_ANG][CORDIC_STEPS+1];
  logic               cord_f_r [NUM_ANG][CORDIC_STEPS+1];
  logic signed [33:0] sin_r [NUM_ANG];
  logic signed [33:0] cos_r [NUM_ANG];

  logic signed [67:0] p_crsp_r, p_crcp_r, p_srcp_r, p_srsp_r;
  logic signed [33:0] sy1_r, cy1_r, sy2_r, cy2_r;
  logic signed [33:0] r_crsp_r, r_crcp_r, r_srcp_r, r_srsp_r;
  logic signed [67:0] t_r [8];
  logic signed [68:0] sum_r [4];
  logic signed [68:0] rnd [4];
  logic signed [15:0] sat [4];

  assign en        = !out_valid_r || !out_stall;
  assign q_pop     = en && q_stat.not_empty;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vb_r        <= {vb_r[NB-2:0], q_pop};
      out_valid_r <= vb_r[NB-1];
    end
  end

  // one micro-rotation per stage
  always_ff @(posedge clk) begin
    if (en) begin
      for (int g = 0; g < NUM_ANG; g++) begin
        cord_x_r[g][0] <= INV_GAIN;
        cord_y_r[g][0] <= '0;
        cord_a_r[g][0] <= 34'(q_data[g].ang);
        cord_f_r[g][0] <= q_data[g].flip;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
          cord_f_r[g][i+1] <= cord_f_r[g][i];
          if (!cord_a_r[g][i][33]) begin
            cord_x_r[g][i+1] <= cord_x_r[g][i] - (cord_y_r[g][i] >>> i);
            cord_y_r[g][i+1] <= cord_y_r[g][i] + (cord_x_r[g][i] >>> i);
            cord_a_r[g][i+1] <= cord_a_r[g][i] - $signed(34'(ATAN_TAB[i]));
          end else begin
            cord_x_r[g][i+1] <= cord_x_r[g][i] + (cord_y_r[g][i] >>> i);
            cord_y_r[g][i+1] <= cord_y_r[g][i] - (cord_x_r[g][i] >>> i);
            cord_a_r[g][i+1] <= cord_a_r[g][i] + $signed(34'(ATAN_TAB[i]));
          end
        end
        sin_r[g] <= cord_f_r[g][CORDIC_STEPS] ? -cord_y_r[g][CORDIC_STEPS]
                                               :  cord_y_r[g][CORDIC_STEPS];
        cos_r[g] <= cord_f_r[g][CORDIC_STEPS] ? -cord_x_r[g][CORDIC_STEPS]
                                               :  cord_x_r[g][CORDIC_STEPS];
      end
    end
  end

  // lane 0 pitch, 1 yaw, 2 roll
  always_ff @(posedge clk) begin
    if (en) begin
      p_crsp_r <= cos_r[2] * sin_r[0];
      p_crcp_r <= cos_r[2] * cos_r[0];
      p_srcp_r <= sin_r[2] * cos_r[0];
      p_srsp_r <= sin_r[2] * sin_r[0];
      sy1_r    <= sin_r[1];
      cy1_r    <= cos_r[1];

      r_crsp_r <= 34'((p_crsp_r + 68'sd536870912) >>> 30);
      r_crcp_r <= 34'((p_crcp_r + 68'sd536870912) >>> 30);
      r_srcp_r <= 34'((p_srcp_r + 68'sd536870912) >>> 30);
      r_srsp_r <= 34'((p_srsp_r + 68'sd536870912) >>> 30);
      sy2_r    <= sy1_r;
      cy2_r    <= cy1_r;

      t_r[0] <= r_crsp_r * sy2_r;
      t_r[1] <= r_srcp_r * cy2_r;
      t_r[2] <= r_crsp_r * cy2_r;
      t_r[3] <= r_srcp_r * sy2_r;
      t_r[4] <= r_crcp_r * sy2_r;
      t_r[5] <= r_srsp_r * cy2_r;
      t_r[6] <= r_crcp_r * cy2_r;
      t_r[7] <= r_srsp_r * sy2_r;

      sum_r[0] <= 69'(t_r[0]) - 69'(t_r[1]);
      sum_r[1] <= -69'(t_r[2]) - 69'(t_r[3]);
      sum_r[2] <= 69'(t_r[4]) - 69'(t_r[5]);
      sum_r[3] <= 69'(t_r[6]) + 69'(t_r[7]);

      out_word_r.quat_x <= sat[0];
      out_word_r.quat_y <= sat[1];
      out_word_r.quat_z <= sat[2];
      out_word_r.quat_w <= sat[3];
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rnd[k] = (sum_r[k] + (69'sd1 <<< (OSH - 1))) >>> OSH;
      if (rnd[k] > 69'(SAT_MAX)) begin
        sat[k] = SAT_MAX;
      end else if (rnd[k] < 69'(SAT_MIN)) begin
        sat[k] = SAT_MIN;
      end else begin
        sat[k] = 16'(rnd[k]);
      end
    end
  end

endmodule

// ===== design/euler_to_quaternion_top.sv =====
// Top level of the Euler-angle to quaternion converter.
// Usage:
//   Input channel (in_valid / in_stall / in_word) takes pitch, yaw and roll in
//   signed Q23.8 degrees; one word is taken at each edge with in_valid high and
//   in_stall low. Output channel (out_valid / out_stall / out_word) gives the
//   unit quaternion x, y, z, w in Q1.15, one word per input word, in order.
//   Throughput is one word per cycle while in_stall is low. The path from
//   acceptance to out_valid runs through the seven stage range reduction, the
//   queue, the CORDIC pipeline of CORDIC_STEPS micro-rotation stages and five
//   product and rounding stages.
//   When the receiver stalls, the back end holds its words and stops drawing
//   from the 16-word queue; the front end keeps taking words until the queue
//   and its own pipeline hold 16, then raises in_stall.
//   Reset (rst_n low, synchronous) empties the pipeline and queue; no clearing
//   pass is needed and words are taken from the first cycle after reset.
`include "assert_macros.svh"

module euler_to_quaternion_top #(
  parameter int ANGLE_FRAC_BITS = 8,
  parameter int OUT_FRAC_BITS   = 15,
  parameter int CORDIC_STEPS    = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  euq_pkg::euq_in_t  in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output euq_pkg::euq_out_t out_word
);
  import euq_pkg::*;

  logic       q_push, q_pop;
  euq_qword_t q_wdata, q_rdata;
  euq_qstat_t q_stat;

  euq_front #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_word (in_word),
    .q_pop   (q_pop),
    .q_push  (q_push),
    .q_data  (q_wdata)
  );

  euq_fifo u_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata(q_wdata),
    .pop  (q_pop),
    .rdata(q_rdata),
    .stat (q_stat)
  );

  euq_back #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .OUT_FRAC_BITS(OUT_FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .q_data   (q_rdata),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  `EUQ_ASSERT_IMP(a_push_room, q_push, !q_stat.full, "queue overrun")
  `EUQ_ASSERT_IMP(a_pop_data, q_pop, q_stat.not_empty, "queue underrun")
  `EUQ_ASSERT_IMP(a_pop_held, out_valid && out_stall, !q_pop, "pop while back end held")
  `EUQ_ASSERT_NXT(a_push_seen, q_push && !q_pop, q_stat.not_empty, "pushed word lost")

endmodule

// ===== verif/euq_checker.sv =====
// Checker for the Euler-angle to quaternion converter: predicts and compares output words.
`timescale 1ns / 100ps

module euq_checker #(
  parameter int ANGLE_FRAC_BITS = 8,
  parameter int OUT_FRAC_BITS   = 15,
  parameter int CORDIC_STEPS    = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  euq_pkg::euq_in_t  in_word,
  input  logic              out_valid,
  input  logic              out_stall,
  input  euq_pkg::euq_out_t out_word,
  output int                fail_count,
  output int                pending,
  output int                words_checked
);
  import euq_pkg::*;

  euq_out_t quat_q[$];

  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rnd_shift(longint v, int s);
    if (s == 0) return v;
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint half_turns(logic signed [31:0] deg);
    longint m, d, r, q;
    longint unsigned mag;
    m = longint'(360) <<< ANGLE_FRAC_BITS;
    d = longint'(720) <<< ANGLE_FRAC_BITS;
    r = longint'(deg) % m;
    mag = r < 0 ? -r : r;
    q = ((mag << 32) + d / 2) / d;
    return r < 0 ? -q : q;
  endfunction

  task automatic sin_cos(input longint a, output longint s, output longint c);
    bit flip;
    longint x, y, nx, ny;
    flip = 0;
    x = INV_GAIN;
    y = 0;
    if (a > QUARTER_TURN) begin
      a -= HALF_TURN;
      flip = 1;
    end else if (a < -QUARTER_TURN) begin
      a += HALF_TURN;
      flip = 1;
    end
    for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
      if (a >= 0) begin
        nx = x - asr(y, i);
        ny = y + asr(x, i);
        a -= longint'(ATAN_TAB[i]);
      end else begin
        nx = x + asr(y, i);
        ny = y - asr(x, i);
        a += longint'(ATAN_TAB[i]);
      end
      x = nx;
      y = ny;
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endtask

  function automatic longint prod3(longint a, longint b, longint c);
    return rnd_shift(a * b, 30) * c;
  endfunction

  function automatic logic signed [15:0] to_q15(longint v60);
    longint v;
    v = rnd_shift(v60, 60 - OUT_FRAC_BITS);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  task automatic predict_quat(input euq_in_t w, output euq_out_t q);
    longint sp, cp, sy, cy, sr, cr;
    sin_cos(half_turns(w.pitch_deg), sp, cp);
    sin_cos(half_turns(w.yaw_deg), sy, cy);
    sin_cos(half_turns(w.roll_deg), sr, cr);
    q.quat_x = to_q15(prod3(cr, sp, sy) - prod3(sr, cp, cy));
    q.quat_y = to_q15(-prod3(cr, sp, cy) - prod3(sr, cp, sy));
    q.quat_z = to_q15(prod3(cr, cp, sy) - prod3(sr, sp, cy));
    q.quat_w = to_q15(prod3(cr, cp, cy) + prod3(sr, sp, sy));
  endtask

  assign pending = quat_q.size();

  always @(posedge clk) begin
    euq_out_t q, e;
    if (!rst_n) begin
      fail_count <= 0;
      words_checked <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_quat(in_word, q);
        quat_q.push_back(q);
      end
      if (out_valid && !out_stall) begin
        words_checked <= words_checked + 1;
        if (quat_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected output word %h", out_word);
          fail_count <= fail_count + 1;
        end else begin
          e = quat_q.pop_front();
          if (e !== out_word) begin
            if (fail_count < 10)
              $display("mismatch x %0d/%0d y %0d/%0d z %0d/%0d w %0d/%0d (exp/act)",
                e.quat_x, out_word.quat_x, e.quat_y, out_word.quat_y,
                e.quat_z, out_word.quat_z, e.quat_w, out_word.quat_w);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ===== verif/tb_euler_to_quaternion_top.sv =====
// Testbench top for the Euler-angle to quaternion converter: stimulus and verdict.
`timescale 1ns / 100ps

module tb_euler_to_quaternion_top;
  import euq_pkg::*;

  logic     clk = 0;
  logic     rst_n = 0;
  logic     in_valid = 0;
  logic     in_stall;
  euq_in_t  in_word = '0;
  logic     out_valid;
  logic     out_stall = 0;
  euq_out_t out_word;
  int       fail_count, pending, words_checked;
  int       hold_cycles = 0;
  bit       sent_all = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  euler_to_quaternion_top u_top (.*);

  euq_checker u_chk (.*);

  function automatic logic signed [31:0] rand_angle();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $signed($urandom_range(0, 2 * 92160)) - 92160;
      2: return (($urandom_range(0, 16) - 8) * 90) <<< 8;
      3: return $signed($urandom_range(0, 1024)) - 512;
      default: return $signed($urandom_range(0, 2 * 46080)) - 46080;
    endcase
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_word(input euq_in_t w);
    int g;
    g = gap_len();
    if ($urandom_range(0, 3) == 0) g = 0;
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // receiver back-pressure; one long hold early on to fill the queue
  initial begin
    int g;
    @(posedge rst_n);
    repeat (60) @(posedge clk);
    out_stall <= 1;
    while (hold_cycles < 200) begin
      @(posedge clk);
      hold_cycles++;
    end
    out_stall <= 0;
    forever begin
      g = gap_len();
      if (g > 0) begin
        out_stall <= 1;
        repeat (g) @(posedge clk);
      end
      out_stall <= 0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  initial begin
    logic signed [31:0] edge_vals[$];
    euq_in_t w;
    edge_vals = '{32'sh7FFFFFFF, 32'sh80000000, 0, 1, -1, 360 <<< 8, -(360 <<< 8),
                  180 <<< 8, -(180 <<< 8), 90 <<< 8, 270 <<< 8, -(270 <<< 8),
                  (180 <<< 8) + 1, (360 <<< 8) - 1, 32'shAAAAAAAA, 32'sh55555555};
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    foreach (edge_vals[i]) begin
      w.pitch_deg = edge_vals[i];
      w.yaw_deg = edge_vals[(i + 5) % edge_vals.size()];
      w.roll_deg = edge_vals[(i + 11) % edge_vals.size()];
      send_word(w);
    end
    for (int i = 0; i < 650; i++) begin
      w.pitch_deg = rand_angle();
      w.yaw_deg = rand_angle();
      w.roll_deg = rand_angle();
      send_word(w);
    end
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("covered %0d words: angle extremes, wrap and quarter-turn edges, random angles",
      words_checked);
    $display("with random idling on both sides and one long receiver hold-off");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end
endmodule
